// ===== hw/rtl/kcfe_pkg.sv =====
// Package of the KICK command field extractor: types, codes and helper functions.
`default_nettype none
package kcfe_pkg;

    localparam int unsigned MinLen   = 11;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QAddrW   = 2;
    localparam int unsigned QCountW  = 3;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChComma = 8'h2C;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChDel   = 8'h7F;
    localparam logic [7:0] ChLow   = 8'h20;

    localparam logic [1:0] SelChannel = 2'd0;
    localparam logic [1:0] SelUser    = 2'd1;
    localparam logic [1:0] SelReason  = 2'd2;

    typedef enum logic [2:0] {
        VC_OK        = 3'd0,
        VC_PREFIX    = 3'd1,
        VC_SHORT     = 3'd2,
        VC_BAD_CHAN  = 3'd3,
        VC_NO_USER   = 3'd4,
        VC_NO_COLON  = 3'd5,
        VC_NO_CRLF   = 3'd6
    } verdict_t;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_CHAN   = 3'd1,
        PH_USER   = 3'd2,
        PH_COLON  = 3'd3,
        PH_REASON = 3'd4,
        PH_DEAD   = 3'd5
    } phase_t;

    // One queue entry: what a single accepted beat produced.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] field_byte;
        logic       has_verdict;
        verdict_t   code;
    } entry_t;

    function automatic logic [7:0] prefix_byte(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h4B;
            4'd1:    c = 8'h49;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h4B;
            4'd4:    c = 8'h20;
            4'd5:    c = 8'h23;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic chan_ok(input logic [7:0] c);
        return (c >= ChLow) && (c < ChDel) && (c != ChComma) && (c != ChColon);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/kcfe_front.sv =====
// Front part: accepts line bytes, tracks the parse and classifies each beat.
`default_nettype none
module kcfe_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_line,
    input  wire logic [1:0]         field_select,
    output kcfe_pkg::entry_t        entry,
    output logic                    entry_valid
);

    kcfe_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       count_reg, count_next;
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [1:0]       fill_reg, fill_next;
    logic [2:0]       err_reg, err_next;

    kcfe_pkg::phase_t phase_after;
    logic [3:0]       count_after;
    logic [2:0]       err_after;
    logic             crlf;
    logic [1:0]       sel;
    logic             emit;

    assign sel = (field_select == 2'd3) ? kcfe_pkg::SelReason : field_select;

    // Next state.
    always_comb
    begin
        logic [7:0] conf;
        conf        = held0_reg;
        phase_after = phase_reg;
        err_after   = err_reg;
        held0_next  = held0_reg;
        held1_next  = held1_reg;
        fill_next   = fill_reg;

        if (count_reg < 4'd6 && data_byte != kcfe_pkg::prefix_byte(count_reg)
                && err_after == kcfe_pkg::VC_OK)
        begin
            err_after   = kcfe_pkg::VC_PREFIX;
            phase_after = kcfe_pkg::PH_DEAD;
        end
        count_after = (count_reg < 4'(kcfe_pkg::MinLen)) ? count_reg + 4'd1 : count_reg;

        if (fill_reg == 2'd2)
        begin
            held0_next = held1_reg;
            held1_next = data_byte;
            case (phase_after)
                kcfe_pkg::PH_PREFIX:
                begin
                    if (count_reg >= 4'd7)
                        phase_after = kcfe_pkg::PH_CHAN;
                end
                kcfe_pkg::PH_CHAN:
                begin
                    if (conf == kcfe_pkg::ChSpace)
                        phase_after = kcfe_pkg::PH_USER;
                    else if (!kcfe_pkg::chan_ok(conf))
                    begin
                        if (err_after == kcfe_pkg::VC_OK)
                            err_after = kcfe_pkg::VC_BAD_CHAN;
                        phase_after = kcfe_pkg::PH_DEAD;
                    end
                end
                kcfe_pkg::PH_USER:
                begin
                    if (conf == kcfe_pkg::ChSpace)
                        phase_after = kcfe_pkg::PH_COLON;
                    else if (conf == 8'h00)
                    begin
                        if (err_after == kcfe_pkg::VC_OK)
                            err_after = kcfe_pkg::VC_NO_CRLF;
                        phase_after = kcfe_pkg::PH_DEAD;
                    end
                end
                kcfe_pkg::PH_COLON:
                begin
                    if (conf == kcfe_pkg::ChColon)
                        phase_after = kcfe_pkg::PH_REASON;
                    else
                    begin
                        if (err_after == kcfe_pkg::VC_OK)
                            err_after = kcfe_pkg::VC_NO_COLON;
                        phase_after = kcfe_pkg::PH_DEAD;
                    end
                end
                kcfe_pkg::PH_REASON:
                begin
                    if (conf == 8'h00)
                    begin
                        if (err_after == kcfe_pkg::VC_OK)
                            err_after = kcfe_pkg::VC_NO_CRLF;
                        phase_after = kcfe_pkg::PH_DEAD;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (fill_reg == 2'd1)
        begin
            held1_next = data_byte;
            fill_next  = 2'd2;
        end
        else
        begin
            held0_next = data_byte;
            fill_next  = 2'd1;
        end

        crlf = (fill_next == 2'd2) && (held0_next == kcfe_pkg::ChCr)
               && (held1_next == kcfe_pkg::ChLf);

        if (end_of_line)
        begin
            phase_next = kcfe_pkg::PH_PREFIX;
            count_next = 4'd0;
            fill_next  = 2'd0;
            err_next   = kcfe_pkg::VC_OK;
        end
        else
        begin
            phase_next = phase_after;
            count_next = count_after;
            err_next   = err_after;
        end
    end

    // Outputs. A held byte can only reach a body phase once the prefix is past,
    // so the registered phase decides whether it is emitted.
    always_comb
    begin
        emit = 1'b0;
        if (fill_reg == 2'd2)
        begin
            case (phase_reg)
                kcfe_pkg::PH_CHAN:
                    emit = (held0_reg != kcfe_pkg::ChSpace) && kcfe_pkg::chan_ok(held0_reg)
                           && (sel == kcfe_pkg::SelChannel);
                kcfe_pkg::PH_USER:
                    emit = (held0_reg != kcfe_pkg::ChSpace) && (held0_reg != 8'h00)
                           && (sel == kcfe_pkg::SelUser);
                kcfe_pkg::PH_REASON:
                    emit = (held0_reg != 8'h00) && (sel == kcfe_pkg::SelReason);
                default:
                    emit = 1'b0;
            endcase
        end

        entry.has_byte    = emit;
        entry.field_byte  = held0_reg;
        entry.has_verdict = end_of_line;
        if (err_after == kcfe_pkg::VC_PREFIX)
            entry.code = kcfe_pkg::VC_PREFIX;
        else if (count_after < 4'(kcfe_pkg::MinLen))
            entry.code = kcfe_pkg::VC_SHORT;
        else if (!crlf)
            entry.code = kcfe_pkg::VC_NO_CRLF;
        else if (err_after != kcfe_pkg::VC_OK)
            entry.code = kcfe_pkg::verdict_t'(err_after);
        else if (phase_after == kcfe_pkg::PH_CHAN || phase_after == kcfe_pkg::PH_PREFIX)
            entry.code = kcfe_pkg::VC_NO_USER;
        else if (phase_after == kcfe_pkg::PH_COLON)
            entry.code = kcfe_pkg::VC_NO_COLON;
        else
            entry.code = kcfe_pkg::VC_OK;

        entry_valid = accept && (emit || end_of_line);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kcfe_pkg::PH_PREFIX;
            count_reg <= 4'd0;
            fill_reg  <= 2'd0;
            err_reg   <= kcfe_pkg::VC_OK;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/kcfe_queue.sv =====
// Short FIFO of classified beats between the front and back parts.
`default_nettype none
module kcfe_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire kcfe_pkg::entry_t   push_entry,
    input  wire logic               pop,
    output kcfe_pkg::entry_t        head,
    output logic                    not_empty,
    output logic                    full
);

    kcfe_pkg::entry_t                 slots_reg [kcfe_pkg::QDepth];
    logic [kcfe_pkg::QAddrW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [kcfe_pkg::QCountW-1:0]     count_reg, count_next;

    assign head      = slots_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == kcfe_pkg::QCountW'(kcfe_pkg::QDepth));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/kcfe_back.sv =====
// Back part: turns queued beats into result beats through an output register.
`default_nettype none
module kcfe_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire kcfe_pkg::entry_t   head,
    input  wire logic               head_valid,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    is_verdict,
    output logic [2:0]              verdict_code,
    output logic                    last_of_run
);

    logic       valid_reg;
    logic       byte_done_reg, byte_done_next;
    logic       load;
    logic       send_byte;
    logic [7:0] byte_reg;
    logic       verdict_reg;
    logic [2:0] code_reg;

    assign load      = head_valid && (!valid_reg || out_ready);
    assign send_byte = head.has_byte && !byte_done_reg;

    // A beat with a byte and a verdict leaves the queue after its second result.
    always_comb
    begin
        pop            = 1'b0;
        byte_done_next = byte_done_reg;
        if (load)
        begin
            if (send_byte && head.has_verdict)
                byte_done_next = 1'b1;
            else
            begin
                pop            = 1'b1;
                byte_done_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            byte_done_reg <= byte_done_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= send_byte ? head.field_byte : 8'h00;
            verdict_reg <= !send_byte;
            code_reg    <= send_byte ? 3'(kcfe_pkg::VC_OK) : 3'(head.code);
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign is_verdict   = verdict_reg;
    assign verdict_code = code_reg;
    assign last_of_run  = verdict_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/kick_command_field_extractor_core.sv =====
// Top level of the KICK command field extractor with its configuration port.
// The block takes one command line "KICK #channel user [:reason]" CR LF, one
// byte per input beat on data_byte with end_of_line set on the final byte.
// Input beats are accepted when in_valid and in_ready are both high; one
// byte per clock is taken as long as the internal four-entry queue has room.
// The front part checks the line and holds back the last two bytes, so a
// body byte is confirmed when two later bytes have arrived. Confirmed bytes
// of the field chosen by field_select come out as byte beats; the final
// byte of a line also yields a verdict beat with is_verdict and last_of_run
// set and verdict_code giving success or an error, where prefix, length and
// trailer faults rank ahead of the first body error. The receiver drops the
// line's bytes when the code is not ok. A result passes through the queue and
// then the output register; the line's last beat can give two results, the
// byte and then the verdict. When the receiver holds out_ready low the result
// stays put, the queue fills behind it, and in_ready falls once the queue is full.
// field_select sits at APB address 0 and resets to channel; write it only
// while the block is idle. Reset clears the parse state, the queue and the
// output register; the block is ready for a new line in the first cycle after.
`default_nettype none
module kick_command_field_extractor_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_line,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_byte,
    output logic             is_verdict,
    output logic [2:0]       verdict_code,
    output logic             last_of_run
);

    logic [1:0]       field_select_reg;
    logic             accept;
    kcfe_pkg::entry_t front_entry;
    logic             front_valid;
    kcfe_pkg::entry_t head;
    logic             head_valid;
    logic             queue_full;
    logic             pop;

    // Only one register exists; bit 2 of the address selects beyond it.
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'h0 : {30'h0, field_select_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_select_reg <= 2'd0;
        else if (psel && penable && pwrite && !paddr[2])
            field_select_reg <= pwdata[1:0];
    end

    // The queue never drains and fills in the same count step past its depth,
    // so readiness follows the full flag alone.
    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    kcfe_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .end_of_line  (end_of_line),
        .field_select (field_select_reg),
        .entry        (front_entry),
        .entry_valid  (front_valid)
    );

    kcfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_entry (front_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (head_valid),
        .full       (queue_full)
    );

    kcfe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_verdict   (is_verdict),
        .verdict_code (verdict_code),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire

// ===== verif/kick_command_field_extractor_core_tb.sv =====
// Self-checking testbench for the KICK command field extractor core.
`timescale 1ns / 1ps

module kick_command_field_extractor_core_tb;
    import kcfe_pkg::*;

    // The prefix every line must start with, most significant byte first.
    localparam logic [47:0] KickPrefix = "KICK #";
    localparam logic [7:0] ChCarriage = 8'd13;
    localparam logic [7:0] ChNewline = 8'd10;
    localparam logic [2:0] AddrFieldSelect = 3'd0;
    localparam int NoCode = -1;
    localparam int RandomBeats = 950;
    localparam int StallLimit = 4000;
    // Cycles left for a beat that produces no result to clear the pipeline.
    localparam int SettleCycles = 8;
    localparam int NumDirected = 24;

    // One beat the block is expected to send back.
    typedef struct packed {
        logic [7:0] ch;
        logic       verdict;
        verdict_t   code;
        logic       last;
    } extract_t;

    // One row of the directed table. The code column holds the verdict that
    // can be read straight off the line; NoCode leaves it to the predictor.
    // poke_at replaces one byte of the text, which lets zero and high bytes
    // into a line. switch_at changes field_select in front of that byte.
    typedef struct {
        string      text;
        bit         crlf;
        logic [1:0] sel;
        int         code;
        int         poke_at;
        logic [7:0] poke_val;
        int         switch_at;
        logic [1:0] switch_to;
    } directed_line_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        end_of_line = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        is_verdict;
    logic [2:0]  verdict_code;
    logic        last_of_run;

    // Predictor state: a private copy of the line parser and of the register.
    logic [1:0] fsel;
    phase_t     phase;
    logic [3:0] count;
    logic [7:0] held0;
    logic [7:0] held1;
    logic [1:0] fill;
    verdict_t   first_err;

    extract_t   queued_extracts[$];
    logic [7:0] line_buf[$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    bit         calm = 1'b0;

    directed_line_t dir_tab [NumDirected] = '{
        // Plain good lines, one per selector, the first one straight after reset.
        '{"KICK #c u :r", 1'b1, SelChannel, VC_OK, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c u :r", 1'b1, SelUser, VC_OK, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c u :r", 1'b1, SelReason, VC_OK, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c u :r", 1'b1, 2'd3, VC_OK, NoCode, 8'h00, NoCode, 2'd0},
        // No reason at all, and an empty channel.
        '{"KICK #ch us", 1'b1, SelUser, VC_OK, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK # uu", 1'b1, SelChannel, VC_OK, NoCode, 8'h00, NoCode, 2'd0},
        // Channel never closed by a space, and a user whose space is followed by nothing or by no colon.
        '{"KICK #chan", 1'b1, SelChannel, VC_NO_USER, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c u ", 1'b1, SelUser, VC_NO_COLON, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c u x", 1'b1, SelUser, VC_NO_COLON, NoCode, 8'h00, NoCode, 2'd0},
        // Forbidden channel bytes: comma, colon, DEL, all ones, control, zero.
        '{"KICK #a,b u", 1'b1, SelChannel, VC_BAD_CHAN, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #a:b u", 1'b1, SelChannel, VC_BAD_CHAN, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #aXb u", 1'b1, SelChannel, VC_BAD_CHAN, 7, 8'h7F, NoCode, 2'd0},
        '{"KICK #aXb u", 1'b1, SelChannel, VC_BAD_CHAN, 7, 8'hFF, NoCode, 2'd0},
        '{"KICK #aXb u", 1'b1, SelChannel, VC_BAD_CHAN, 7, 8'h1F, NoCode, 2'd0},
        '{"KICK #aXb u", 1'b1, SelChannel, VC_BAD_CHAN, 7, 8'h00, NoCode, 2'd0},
        // Broken prefix, a zero byte in the prefix, and short lines.
        '{"kICK #c u :r", 1'b1, SelChannel, VC_PREFIX, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c u :r", 1'b1, SelChannel, VC_PREFIX, 0, 8'h00, NoCode, 2'd0},
        '{"KICK", 1'b0, SelChannel, VC_SHORT, NoCode, 8'h00, NoCode, 2'd0},
        '{"K", 1'b0, SelChannel, VC_SHORT, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #cu", 1'b1, SelChannel, VC_SHORT, NoCode, 8'h00, NoCode, 2'd0},
        // Missing trailer, and zero bytes in the user and in the reason.
        '{"KICK #chan uu", 1'b0, SelUser, VC_NO_CRLF, NoCode, 8'h00, NoCode, 2'd0},
        '{"KICK #c uX", 1'b1, SelUser, VC_NO_CRLF, 9, 8'h00, NoCode, 2'd0},
        '{"KICK #c u :rX", 1'b1, SelReason, VC_NO_CRLF, 12, 8'h00, NoCode, 2'd0},
        // Selector moved from channel to user in the middle of a line.
        '{"KICK #cc uu :rr", 1'b1, SelChannel, NoCode, NoCode, 8'h00, 11, SelUser}
    };

    kick_command_field_extractor_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_line  (end_of_line),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .is_verdict   (is_verdict),
        .verdict_code (verdict_code),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    task automatic note_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Latches the first error of the line and stops further extraction.
    function automatic void latch_error(input verdict_t vc);
        if (first_err == VC_OK)
            first_err = vc;
        phase = PH_DEAD;
    endfunction

    function automatic void clear_line();
        phase = PH_PREFIX;
        count = '0;
        held0 = '0;
        held1 = '0;
        fill = '0;
        first_err = VC_OK;
    endfunction

    // Walks one confirmed body byte through the parse phases. Returns 1 when
    // the byte belongs to the field that field_select picks.
    function automatic bit confirm_body(input logic [7:0] c, input logic [3:0] pos);
        logic [1:0] eff;
        eff = (fsel == 2'd3) ? SelReason : fsel;
        case (phase)
            PH_PREFIX:
            begin
                if (pos >= 4'd7)
                    phase = PH_CHAN;
                return 1'b0;
            end
            PH_CHAN:
            begin
                if (c == ChSpace)
                begin
                    phase = PH_USER;
                    return 1'b0;
                end
                if (c < ChLow || c >= ChDel || c == ChComma || c == ChColon)
                begin
                    latch_error(VC_BAD_CHAN);
                    return 1'b0;
                end
                return eff == SelChannel;
            end
            PH_USER:
            begin
                if (c == ChSpace)
                begin
                    phase = PH_COLON;
                    return 1'b0;
                end
                // A zero byte cuts the line short, so the trailer is missing.
                if (c == 8'h00)
                begin
                    latch_error(VC_NO_CRLF);
                    return 1'b0;
                end
                return eff == SelUser;
            end
            PH_COLON:
            begin
                if (c == ChColon)
                    phase = PH_REASON;
                else
                    latch_error(VC_NO_COLON);
                return 1'b0;
            end
            PH_REASON:
            begin
                if (c == 8'h00)
                begin
                    latch_error(VC_NO_CRLF);
                    return 1'b0;
                end
                return eff == SelReason;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Works out what one accepted input beat must produce and queues it.
    // A code other than NoCode overrides the verdict with the table's value.
    function automatic void extract_step(input logic [7:0] b, input bit eol, input int forced);
        logic [3:0] pos;
        logic [7:0] conf;
        bit         crlf;
        verdict_t   vc;
        pos = count;
        if (pos < 4'd6 && b != KickPrefix[47 - 8 * pos -: 8] && first_err == VC_OK)
            latch_error(VC_PREFIX);
        if (count < MinLen)
            count++;

        // Two bytes are always held back, since they may be the CR LF trailer.
        if (fill == 2'd2)
        begin
            conf = held0;
            held0 = held1;
            held1 = b;
            if (confirm_body(conf, pos))
                queued_extracts.push_back('{conf, 1'b0, VC_OK, 1'b0});
        end
        else if (fill == 2'd1)
        begin
            held1 = b;
            fill = 2'd2;
        end
        else
        begin
            held0 = b;
            fill = 2'd1;
        end

        if (eol)
        begin
            crlf = fill == 2'd2 && held0 == ChCarriage && held1 == ChNewline;
            if (first_err == VC_PREFIX)
                vc = VC_PREFIX;
            else if (count < MinLen)
                vc = VC_SHORT;
            else if (!crlf)
                vc = VC_NO_CRLF;
            else if (first_err != VC_OK)
                vc = first_err;
            else if (phase == PH_CHAN || phase == PH_PREFIX)
                vc = VC_NO_USER;
            else if (phase == PH_COLON)
                vc = VC_NO_COLON;
            else
                vc = VC_OK;
            if (forced != NoCode)
                vc = verdict_t'(forced[2:0]);
            queued_extracts.push_back('{8'h00, 1'b1, vc, 1'b1});
            clear_line();
        end
    endfunction

    // Drives one input beat, holding it until the block takes it, and then
    // feeds the predictor. The caller is always sitting on a rising edge.
    task automatic send_beat(input logic [7:0] b, input bit eol, input int forced);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < 20)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_line <= eol;
        do
            @(posedge clk);
        while (!in_ready);
        extract_step(b, eol, forced);
    endtask

    // Stops the sender, lets every owed beat come back and a beat still in flight
    // settle, and then writes field_select over APB.
    task automatic park_and_write(input logic [1:0] value);
        in_valid <= 1'b0;
        while (queued_extracts.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AddrFieldSelect;
        pwdata <= {30'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The register is written at this edge; pready is always high.
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        fsel = value;
    endtask

    // Sends the bytes held in line_buf as one line, end_of_line on the last.
    task automatic send_line(input int forced, input int switch_at, input logic [1:0] switch_to);
        int i;
        for (i = 0; i < line_buf.size(); i++)
        begin
            if (i == switch_at)
                park_and_write(switch_to);
            send_beat(line_buf[i], i == line_buf.size() - 1, forced);
        end
    endtask

    // Receiver side: random back-pressure and the field-by-field check of every
    // result beat against the oldest owed one.
    always @(posedge clk)
    begin
        extract_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (queued_extracts.size() == 0)
                note_mismatch($sformatf("unexpected beat byte %02h verdict %0b code %0d",
                                        out_byte, is_verdict, verdict_code));
            else
            begin
                want = queued_extracts.pop_front();
                if (out_byte !== want.ch)
                    note_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, want.ch));
                if (is_verdict !== want.verdict)
                    note_mismatch($sformatf("is_verdict %0b, expected %0b",
                                            is_verdict, want.verdict));
                if (verdict_code !== want.code)
                    note_mismatch($sformatf("verdict_code %0d, expected %0d",
                                            verdict_code, want.code));
                if (last_of_run !== want.last)
                    note_mismatch($sformatf("last_of_run %0b, expected %0b",
                                            last_of_run, want.last));
            end
        end
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int             row;
        int             i;
        int             n;
        int             lines;
        int             beats_sent;
        int             pick;
        logic [7:0]     c;
        directed_line_t dl;

        fsel = SelChannel;
        clear_line();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: one table row per line, the selector set per row.
        for (row = 0; row < NumDirected; row++)
        begin
            dl = dir_tab[row];
            if (dl.sel != fsel)
                park_and_write(dl.sel);
            line_buf = {};
            for (i = 0; i < dl.text.len(); i++)
                line_buf.push_back(dl.text[i]);
            if (dl.crlf)
            begin
                line_buf.push_back(ChCarriage);
                line_buf.push_back(ChNewline);
            end
            if (dl.poke_at != NoCode)
                line_buf[dl.poke_at] = dl.poke_val;
            send_line(dl.code, dl.switch_at, dl.switch_to);
        end

        // Random part: mostly well-formed lines with random content, some with
        // a broken piece, and a share of plain noise. Lines 20 to 34 run with
        // no idling on either side.
        beats_sent = 0;
        lines = 0;
        while (beats_sent < RandomBeats)
        begin
            calm = lines >= 20 && lines < 35;
            if ($urandom_range(0, 9) == 0)
                park_and_write(2'($urandom_range(0, 3)));
            line_buf = {};
            if ($urandom_range(0, 99) < 8)
            begin
                n = $urandom_range(1, 16);
                repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                for (i = 0; i < 6; i++)
                    line_buf.push_back(KickPrefix[47 - 8 * i -: 8]);
                if ($urandom_range(0, 19) == 0)
                    line_buf[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
                // Channel: mostly legal bytes, now and then anything at all.
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    if ($urandom_range(0, 15) == 0)
                        c = 8'($urandom_range(0, 255));
                    else
                    begin
                        c = 8'($urandom_range(33, 126));
                        if (c == ChComma || c == ChColon)
                            c = "a";
                    end
                    line_buf.push_back(c);
                end
                if ($urandom_range(0, 9) != 0)
                begin
                    line_buf.push_back(ChSpace);
                    n = $urandom_range(0, 5);
                    repeat (n)
                        line_buf.push_back(($urandom_range(0, 19) == 0) ?
                                           8'($urandom_range(0, 255)) :
                                           8'($urandom_range(33, 126)));
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                    begin
                        line_buf.push_back(ChSpace);
                        line_buf.push_back(ChColon);
                        n = $urandom_range(0, 6);
                        repeat (n)
                            line_buf.push_back(($urandom_range(0, 19) == 0) ?
                                               8'($urandom_range(0, 255)) :
                                               8'($urandom_range(32, 126)));
                    end
                    else if (pick == 6)
                        line_buf.push_back(ChSpace);
                    else if (pick == 7)
                    begin
                        line_buf.push_back(ChSpace);
                        line_buf.push_back(8'($urandom_range(0, 255)));
                    end
                end
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    line_buf.push_back(ChCarriage);
                    line_buf.push_back(ChNewline);
                end
                else if (pick == 8)
                    line_buf.push_back(ChCarriage);
            end
            send_line(NoCode, NoCode, 2'd0);
            beats_sent += line_buf.size();
            lines++;
        end
        calm = 1'b0;

        // Drain: wait until every owed beat has come back, then a little more
        // so that a stray extra beat would still be caught.
        in_valid <= 1'b0;
        while (queued_extracts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
